[src/cmn_pkg.sv]
// package for the 3x3 convolution and min/max normalisation block
// shared constants, types and controller/datapath command structs; no dependencies
package cmn_pkg;

  localparam int unsigned DefMaxRows = 64;
  localparam int unsigned DefMaxCols = 64;
  localparam int unsigned RawW       = 20;
  localparam int unsigned CfgW       = 24;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned PixW       = 8;
  localparam int unsigned DimW       = 7;
  localparam int unsigned QuoW       = 9;

  localparam logic [CfgIdxW-1:0] RegRows   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCols   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKTop   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKMid   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKBot   = 3'd4;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdRead = 1'b1;

  // controller states, one-hot
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StConv  = 6'b000010,
    StFetch = 6'b000100,
    StDiv   = 6'b001000,
    StOut   = 6'b010000,
    StDrain = 6'b100000
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // store pixel, advance load count
    logic conv_start; // latch dims and start convolution sweep
    logic conv_step;  // advance the convolution sweep
    logic fetch;      // issue raw store read for current read index
    logic div_start;  // start division
    logic div_step;   // one quotient bit
    logic out_load;   // load output register from result
    logic nr_load;    // load output register with not-ready result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_done;  // this load completes the frame
    logic conv_done;   // sweep finished (last write issued)
    logic div_done;    // quotient complete
    logic need_div;    // interior pixel on a non-flat frame
  } dp_sts_t;

endpackage

[src/cmn_datapath.sv]
// datapath: pixel and raw memories, convolution sweep, min/max, serial divider
// depends on cmn_pkg
module cmn_datapath #(
  parameter int unsigned MaxRows = cmn_pkg::DefMaxRows,
  parameter int unsigned MaxCols = cmn_pkg::DefMaxCols
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cmn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cmn_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [cmn_pkg::PixW-1:0]    pixel_i,
  input  cmn_pkg::dp_cmd_t            cmd_i,
  output cmn_pkg::dp_sts_t            sts_o,
  output logic                        frame_ready_o,
  output logic [cmn_pkg::PixW-1:0]    value_o,
  output logic                        last_o,
  output logic                        not_ready_o
);
  import cmn_pkg::*;

  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned RW    = $clog2(MaxRows + 1);
  localparam int unsigned CW    = $clog2(MaxCols + 1);
  localparam int unsigned DW    = (RW > DimW) ? RW : DimW;
  localparam int unsigned DcW   = (CW > DimW) ? CW : DimW;
  localparam int unsigned DivW  = RawW + 1;
  localparam int unsigned NumW  = DivW + 8;

  // configuration registers
  logic [DimW-1:0] rows_cfg_q, cols_cfg_q;
  logic [CfgW-1:0] ktop_q, kmid_q, kbot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= DimW'(64);
      cols_cfg_q <= DimW'(64);
      ktop_q     <= '0;
      kmid_q     <= '0;
      kbot_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRows: rows_cfg_q <= cfg_data_i[DimW-1:0];
        RegCols: cols_cfg_q <= cfg_data_i[DimW-1:0];
        RegKTop: ktop_q     <= cfg_data_i;
        RegKMid: kmid_q     <= cfg_data_i;
        RegKBot: kbot_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated dimensions
  logic [DW-1:0]  rows_ext;
  logic [DcW-1:0] cols_ext;
  logic [RW-1:0]  rows_sat;
  logic [CW-1:0]  cols_sat;
  assign rows_ext = DW'(rows_cfg_q);
  assign cols_ext = DcW'(cols_cfg_q);
  always_comb begin
    if (rows_ext < DW'(3))            rows_sat = RW'(3);
    else if (rows_ext > DW'(MaxRows)) rows_sat = RW'(MaxRows);
    else                              rows_sat = RW'(rows_ext);
    if (cols_ext < DcW'(3))           cols_sat = CW'(3);
    else if (cols_ext > DcW'(MaxCols)) cols_sat = CW'(MaxCols);
    else                              cols_sat = CW'(cols_ext);
  end

  // load count and frame state
  logic [CntW-1:0] load_cnt_q, load_base, load_next;
  logic            frame_ready_q;
  logic [RW-1:0]   frows_q;
  logic [CW-1:0]   fcols_q;
  logic [CntW+1:0] area;
  assign area      = (CntW+2)'(rows_sat) * (CntW+2)'(cols_sat);
  assign load_base = frame_ready_q ? '0 : load_cnt_q;
  assign load_next = load_base + CntW'(1);
  assign sts_o.frame_done = ((CntW+2)'(load_next) >= area);

  // convolution sweep: row r, column c, tap t (0..8), then write
  logic [RW-1:0] cr_q;
  logic [CW-1:0] cc_q;
  logic [3:0]    tap_q;
  logic          conv_act_q;
  logic signed [RawW-1:0] acc_q;
  logic          first_q;
  logic signed [RawW-1:0] min_q, max_q;

  logic border;
  assign border = (cr_q == '0) || (cc_q == '0) || (cr_q == frows_q - RW'(1)) ||
                  (cc_q == fcols_q - CW'(1));

  // tap address
  logic [1:0] ti, tj;
  assign ti = (tap_q < 4'd3) ? 2'd0 : (tap_q < 4'd6) ? 2'd1 : 2'd2;
  assign tj = 2'(tap_q - 4'(ti) * 4'd3);
  logic [AW-1:0] tap_addr, cur_addr;
  assign tap_addr = AW'((AW+1)'(cr_q + RW'(ti) - RW'(1)) * (AW+1)'(fcols_q)
                    + (AW+1)'(cc_q + CW'(tj) - CW'(1)));
  assign cur_addr = AW'((AW+1)'(cr_q) * (AW+1)'(fcols_q) + (AW+1)'(cc_q));

  // pixel memory; tap read issued in cycle of tap, used next cycle
  logic [PixW-1:0] pix_mem [Depth];
  logic [PixW-1:0] pix_rd_q;
  logic [AW-1:0]   pix_rd_addr;
  assign pix_rd_addr = tap_addr;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (load_base < CntW'(Depth))) pix_mem[AW'(load_base)] <= pixel_i;
    pix_rd_q <= pix_mem[pix_rd_addr];
  end

  // coefficient of the previous tap
  logic [3:0]  tap_d1_q;
  logic        tap_v_q;
  logic [CfgW-1:0] krow;
  logic [1:0]  pi, pj;
  logic signed [7:0] coef;
  assign pi = (tap_d1_q < 4'd3) ? 2'd0 : (tap_d1_q < 4'd6) ? 2'd1 : 2'd2;
  assign pj = 2'(tap_d1_q - 4'(pi) * 4'd3);
  always_comb begin
    case (pi)
      2'd0:    krow = ktop_q;
      2'd1:    krow = kmid_q;
      default: krow = kbot_q;
    endcase
    case (pj)
      2'd0:    coef = krow[7:0];
      2'd1:    coef = krow[15:8];
      default: coef = krow[23:16];
    endcase
  end
  // pixel times coefficient, both widened to the raw sum width
  logic signed [RawW-1:0] prod;
  assign prod = $signed({{(RawW-PixW){1'b0}}, pix_rd_q}) *
                $signed({{(RawW-8){coef[7]}}, coef});

  // raw memory
  logic signed [RawW-1:0] raw_mem [Depth];
  logic signed [RawW-1:0] raw_rd_q;
  logic                   raw_we;
  logic [AW-1:0]          raw_waddr;
  logic signed [RawW-1:0] raw_wdata;
  logic [CntW-1:0]        rd_cnt_q;
  always_ff @(posedge clk_i) begin
    if (raw_we) raw_mem[raw_waddr] <= raw_wdata;
    if (cmd_i.fetch) raw_rd_q <= raw_mem[AW'(rd_cnt_q)];
  end

  logic signed [RawW-1:0] sum_fin;
  assign sum_fin = acc_q + prod;
  logic last_cell;
  assign last_cell = (cr_q == frows_q - RW'(1)) && (cc_q == fcols_q - CW'(1));
  logic wr_phase; // tap 9 or a border cell means write cycle
  assign wr_phase = (tap_q == 4'd9) || border;

  always_comb begin
    raw_we    = conv_act_q && wr_phase;
    raw_waddr = cur_addr;
    raw_wdata = border ? '0 : sum_fin;
  end
  assign sts_o.conv_done = conv_act_q && wr_phase && last_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q    <= '0;
      frame_ready_q <= 1'b0;
      frows_q       <= RW'(3);
      fcols_q       <= CW'(3);
      conv_act_q    <= 1'b0;
      cr_q          <= '0;
      cc_q          <= '0;
      tap_q         <= '0;
      tap_d1_q      <= '0;
      tap_v_q       <= 1'b0;
      acc_q         <= '0;
      first_q       <= 1'b1;
      min_q         <= '0;
      max_q         <= '0;
    end else begin
      if (cmd_i.load) begin
        load_cnt_q    <= load_next;
        frame_ready_q <= 1'b0;
      end
      if (cmd_i.conv_start) begin
        frows_q    <= rows_sat;
        fcols_q    <= cols_sat;
        conv_act_q <= 1'b1;
        cr_q       <= '0;
        cc_q       <= '0;
        tap_q      <= '0;
        tap_v_q    <= 1'b0;
        acc_q      <= '0;
        first_q    <= 1'b1;
      end else if (cmd_i.conv_step && conv_act_q) begin
        tap_d1_q <= tap_q;
        tap_v_q  <= !wr_phase;
        if (tap_v_q) acc_q <= sum_fin;
        if (wr_phase) begin
          acc_q   <= '0;
          tap_q   <= '0;
          tap_v_q <= 1'b0;
          if (!border) begin
            first_q <= 1'b0;
            if (first_q || sum_fin < min_q) min_q <= sum_fin;
            if (first_q || sum_fin > max_q) max_q <= sum_fin;
          end
          if (last_cell) begin
            conv_act_q    <= 1'b0;
            frame_ready_q <= 1'b1;
          end else if (cc_q == fcols_q - CW'(1)) begin
            cc_q <= '0;
            cr_q <= cr_q + RW'(1);
          end else begin
            cc_q <= cc_q + CW'(1);
          end
        end else begin
          tap_q <= tap_q + 4'd1;
        end
      end
    end
  end
  assign frame_ready_o = frame_ready_q;

  // readout position
  logic [RW-1:0] rr_q;
  logic [CW-1:0] rc_q;
  logic [CntW+1:0] total;
  logic          rd_last;
  assign total   = (CntW+2)'(frows_q) * (CntW+2)'(fcols_q);
  assign rd_last = ((CntW+2)'(rd_cnt_q) == total - (CntW+2)'(1));
  logic rd_interior;
  assign rd_interior = (rr_q != '0) && (rc_q != '0) && (rr_q != frows_q - RW'(1)) &&
                       (rc_q != fcols_q - CW'(1));
  assign sts_o.need_div = rd_interior && (max_q != min_q);

  // restoring divider, one quotient bit per cycle
  logic [NumW-1:0] num_q;
  logic [DivW:0]   rem_q;
  logic [DivW-1:0] den_q;
  logic [4:0]      dcnt_q;
  logic [DivW:0]   trial;
  assign trial = {rem_q[DivW-1:0], num_q[NumW-1]} - {1'b0, den_q};
  assign sts_o.div_done = (dcnt_q == 5'(NumW));
  logic [DivW-1:0] diff;
  assign diff = DivW'($signed({raw_rd_q[RawW-1], raw_rd_q}) -
                      $signed({min_q[RawW-1], min_q}));

  logic [PixW-1:0] val_q;
  logic            last_q, nr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      rr_q     <= '0;
      rc_q     <= '0;
      num_q    <= '0;
      rem_q    <= '0;
      den_q    <= '0;
      dcnt_q   <= '0;
      last_q   <= 1'b0;
      nr_q     <= 1'b0;
      val_q    <= '0;
    end else begin
      if (cmd_i.load && frame_ready_q) begin
        rd_cnt_q <= '0;
        rr_q     <= '0;
        rc_q     <= '0;
      end
      if (cmd_i.div_start) begin
        num_q  <= NumW'(diff) * NumW'(255);
        den_q  <= DivW'($signed({max_q[RawW-1], max_q}) - $signed({min_q[RawW-1], min_q}));
        rem_q  <= '0;
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        num_q  <= {num_q[NumW-2:0], !trial[DivW]};
        rem_q  <= trial[DivW] ? {rem_q[DivW-1:0], num_q[NumW-1]} : trial;
        dcnt_q <= dcnt_q + 5'd1;
      end
      if (cmd_i.nr_load) begin
        val_q  <= '0;
        last_q <= 1'b0;
        nr_q   <= 1'b1;
      end else if (cmd_i.out_load) begin
        val_q  <= sts_o.need_div ? num_q[PixW-1:0] : '0;
        last_q <= rd_last;
        nr_q   <= 1'b0;
        if (rd_last) begin
          rd_cnt_q <= '0;
          rr_q     <= '0;
          rc_q     <= '0;
        end else begin
          rd_cnt_q <= rd_cnt_q + CntW'(1);
          if (rc_q == fcols_q - CW'(1)) begin
            rc_q <= '0;
            rr_q <= rr_q + RW'(1);
          end else begin
            rc_q <= rc_q + CW'(1);
          end
        end
      end
    end
  end

  assign value_o     = val_q;
  assign last_o      = last_q;
  assign not_ready_o = nr_q;

endmodule

[src/cmn_ctrl.sv]
// controller state machine: sequences loads, convolution sweep, reads and output
// depends on cmn_pkg
module cmn_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic             frame_ready_i,
  input  cmn_pkg::dp_sts_t sts_i,
  output cmn_pkg::dp_cmd_t cmd_o
);
  import cmn_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        ov_q, ov_d;
  logic        acc;

  // output register is free when empty or being taken
  logic out_free;
  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || !out_free;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && out_stall_i;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (acc && command_i == CmdLoad) begin
          cmd_o.load = 1'b1;
          if (sts_i.frame_done) begin
            cmd_o.conv_start = 1'b1;
            state_d = StConv;
          end
        end else if (acc && command_i == CmdRead) begin
          if (!frame_ready_i) begin
            cmd_o.nr_load = 1'b1;
            ov_d = 1'b1;
          end else begin
            state_d = StFetch;
          end
        end
      end
      StConv: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_done) state_d = StIdle;
      end
      StFetch: begin
        cmd_o.fetch = 1'b1;
        state_d = StDrain;
      end
      StDrain: begin
        cmd_o.div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        if (sts_i.div_done || !sts_i.need_div) state_d = StOut;
        else cmd_o.div_step = 1'b1;
      end
      StOut: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

[src/conv3x3_minmax_normalize.sv]
// top level of the 3x3 convolution and min/max normalisation block
// depends on cmn_pkg, cmn_ctrl and cmn_datapath
//
// Pixels are loaded in raster order, one per cycle while the block is idle and its output
// register is free. The load that completes the frame starts a sweep over the frame;
// no transfer is taken during the sweep. A read of an interior pixel on a non-flat
// frame passes through the fetch, drain, divide and output states, the bit-serial
// divider producing one quotient bit per cycle; a read of a border pixel or on a flat
// frame skips the division. A read made before the frame is complete returns at once
// with not_ready set. The memories need no clearing pass after reset.
module conv3x3_minmax_normalize #(
  parameter int unsigned MaxRows = cmn_pkg::DefMaxRows,
  parameter int unsigned MaxCols = cmn_pkg::DefMaxCols
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cmn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cmn_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [cmn_pkg::PixW-1:0]    pixel_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cmn_pkg::PixW-1:0]    normalized_value_o,
  output logic                        result_last_o,
  output logic                        not_ready_o
);
  import cmn_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    frame_ready;

  // sequencing
  cmn_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_ready_i (frame_ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // storage and arithmetic
  cmn_datapath #(
    .MaxRows (MaxRows),
    .MaxCols (MaxCols)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_i       (pixel_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .frame_ready_o (frame_ready),
    .value_o       (normalized_value_o),
    .last_o        (result_last_o),
    .not_ready_o   (not_ready_o)
  );

endmodule
